### rtl/core/cbc_pkg.sv
// Types and constants shared by the cartridge bank controller.
package cbc_pkg;

    localparam logic [1:0] MBC_ROM_ONLY = 2'd0;
    localparam logic [1:0] MBC_1        = 2'd1;
    localparam logic [1:0] MBC_2        = 2'd2;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [1:0] TGT_NONE   = 2'd0;
    localparam logic [1:0] TGT_ROM_RD = 2'd1;
    localparam logic [1:0] TGT_RAM_RD = 2'd2;
    localparam logic [1:0] TGT_RAM_WR = 2'd3;

    localparam logic [1:0] RGN_RAM_EN   = 2'd0;
    localparam logic [1:0] RGN_ROM_BANK = 2'd1;
    localparam logic [1:0] RGN_HI_BANK  = 2'd2;
    localparam logic [1:0] RGN_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [2:0] RAM_WINDOW   = 3'b101;

    localparam int ROM_OFS_BITS = 14;
    localparam int RAM_OFS_BITS = 13;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  data;
    } cbc_req_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [20:0] cart_address;
        logic [7:0]  write_data;
        logic [6:0]  rom_bank_now;
        logic [1:0]  ram_bank_now;
    } cbc_rsp_t;

endpackage

### rtl/core/cartridge_bank_controller_top.sv
// Cartridge bank controller: bus access decode, bank registers and result register.

// One bus access beat in, one result beat out, one beat per cycle sustained while rsp_ready is
// high. The result is registered, so it appears the cycle after the access is taken; the next
// access is taken in that same cycle unless the held result is stalled. Bank registers change
// as the access is taken, and rom_bank_now / ram_bank_now report them after the access. The
// user writes mbc_type through the cfg channel while no access is in flight; the block does not check.
module cartridge_bank_controller_top
    import cbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic     req_valid,
    output logic     req_ready,
    input  cbc_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output cbc_rsp_t rsp
);

    logic [1:0] mbc_type_reg;
    logic [6:0] rom_bank_reg, rom_bank_next;
    logic [1:0] ram_bank_reg, ram_bank_next;
    logic       ram_en_reg, ram_en_next;
    logic       rom_mode_reg, rom_mode_next;
    logic       rsp_valid_reg;
    cbc_rsp_t   rsp_reg, rsp_next;
    logic       req_fire;
    logic [6:0] bank_cand;
    logic       bank_load;
    logic [20:0] ram_addr;

    assign cfg_ready = 1'b1;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        ram_en_next   = ram_en_reg;
        rom_mode_next = rom_mode_reg;
        bank_cand     = rom_bank_reg;
        bank_load     = 1'b0;
        rsp_next      = '0;

        if (mbc_type_reg == MBC_ROM_ONLY)
        begin
            ram_addr = {8'd0, req.address[RAM_OFS_BITS-1:0]};
        end
        else
        begin
            ram_addr = {6'd0, ram_bank_reg, req.address[RAM_OFS_BITS-1:0]};
        end

        if (!req.address[15])
        begin
            if (req.kind == KIND_WRITE)
            begin
                unique case (mbc_type_reg)
                    MBC_1:
                    begin
                        unique case (req.address[14:13])
                            RGN_RAM_EN:
                                ram_en_next = (req.data[3:0] == RAM_EN_KEY);
                            RGN_ROM_BANK:
                            begin
                                bank_cand = {rom_bank_reg[6:5], req.data[4:0]};
                                bank_load = 1'b1;
                            end
                            RGN_HI_BANK:
                            begin
                                if (rom_mode_reg)
                                begin
                                    bank_cand = {req.data[1:0], rom_bank_reg[4:0]};
                                    bank_load = 1'b1;
                                end
                                else
                                begin
                                    ram_bank_next = req.data[1:0];
                                end
                            end
                            default:
                            begin
                                rom_mode_next = !req.data[0];
                                if (!req.data[0])
                                begin
                                    ram_bank_next = 2'd0;
                                end
                            end
                        endcase
                    end
                    MBC_2:
                    begin
                        if (req.address[14:13] == RGN_RAM_EN && !req.address[4])
                        begin
                            ram_en_next = (req.data[3:0] == RAM_EN_KEY);
                        end
                        else if (req.address[14:13] == RGN_ROM_BANK)
                        begin
                            bank_cand = {3'd0, req.data[3:0]};
                            bank_load = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (bank_load)
                begin
                    rom_bank_next = (bank_cand == 7'd0) ? 7'd1 : bank_cand;
                end
            end
            else
            begin
                rsp_next.target = TGT_ROM_RD;
                if (mbc_type_reg == MBC_ROM_ONLY || !req.address[14])
                begin
                    rsp_next.cart_address = {5'd0, req.address};
                end
                else
                begin
                    rsp_next.cart_address = {rom_bank_reg, req.address[ROM_OFS_BITS-1:0]};
                end
            end
        end
        else if (req.address[15:13] == RAM_WINDOW)
        begin
            if (req.kind == KIND_WRITE)
            begin
                if (mbc_type_reg == MBC_ROM_ONLY || ram_en_reg)
                begin
                    rsp_next.target       = TGT_RAM_WR;
                    rsp_next.cart_address = ram_addr;
                    rsp_next.write_data   = req.data;
                end
            end
            else
            begin
                rsp_next.target       = TGT_RAM_RD;
                rsp_next.cart_address = ram_addr;
            end
        end

        rsp_next.rom_bank_now = rom_bank_next;
        rsp_next.ram_bank_now = ram_bank_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbc_type_reg  <= MBC_ROM_ONLY;
            rom_bank_reg  <= 7'd1;
            ram_bank_reg  <= 2'd0;
            ram_en_reg    <= 1'b0;
            rom_mode_reg  <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mbc_type_reg <= cfg_data;
            end
            if (req_fire)
            begin
                rom_bank_reg  <= rom_bank_next;
                ram_bank_reg  <= ram_bank_next;
                ram_en_reg    <= ram_en_next;
                rom_mode_reg  <= rom_mode_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank_reg != 7'd0)
        else $error("rom bank register holds zero");

    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target == TGT_NONE |-> rsp.cart_address == 21'd0)
        else $error("address on a beat with no cartridge access");

    a_wdata_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target != TGT_RAM_WR |-> rsp.write_data == 8'd0)
        else $error("write data on a beat that is not a RAM write");

    a_now_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp.rom_bank_now == rom_bank_reg && rsp.ram_bank_now == ram_bank_reg)
        else $error("reported banks differ from bank registers");
`endif

endmodule

### bench/tb_top.sv
// Self-checking testbench for the cartridge bank controller: directed table, then random bus accesses.
module tb_top;
    import cbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MBC_SPARE = 2'd3;

    typedef struct packed {
        bit         set_kind;
        logic [1:0] kind_val;
        cbc_req_t   acc;
        bit         typed;
        cbc_rsp_t   want;
    } step_row_t;

    localparam step_row_t directed_rows [30] = '{
        '{1'b0, 2'd0, {KIND_READ,  16'h0000, 8'h00}, 1'b1,
          {TGT_ROM_RD, 21'h000000, 8'h00, 7'd1, 2'd0}},
        '{1'b0, 2'd0, {KIND_READ,  16'h7FFF, 8'hFF}, 1'b1,
          {TGT_ROM_RD, 21'h007FFF, 8'h00, 7'd1, 2'd0}},
        '{1'b0, 2'd0, {KIND_READ,  16'hA000, 8'h00}, 1'b1,
          {TGT_RAM_RD, 21'h000000, 8'h00, 7'd1, 2'd0}},
        '{1'b0, 2'd0, {KIND_WRITE, 16'hBFFF, 8'hFF}, 1'b1,
          {TGT_RAM_WR, 21'h001FFF, 8'hFF, 7'd1, 2'd0}},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h2000, 8'h05}, 1'b1,
          {TGT_NONE,   21'h000000, 8'h00, 7'd1, 2'd0}},
        '{1'b0, 2'd0, {KIND_READ,  16'hFFFF, 8'h00}, 1'b1,
          {TGT_NONE,   21'h000000, 8'h00, 7'd1, 2'd0}},
        '{1'b1, MBC_1, '0, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'hA000, 8'h55}, 1'b1,
          {TGT_NONE,   21'h000000, 8'h00, 7'd1, 2'd0}},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h0000, 8'h0A}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h2000, 8'h00}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h3FFF, 8'hFF}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h4000, 8'h03}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_READ,  16'h7FFF, 8'h00}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h6000, 8'h01}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h5FFF, 8'h03}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'hBFFF, 8'hA5}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h7FFF, 8'hFE}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h1FFF, 8'h0B}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'hA123, 8'h11}, 1'b0, '0},
        '{1'b1, MBC_2, '0, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h0010, 8'h0A}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h0000, 8'hFA}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h2000, 8'hF0}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h3FFF, 8'h0F}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h4000, 8'h03}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_READ,  16'h4000, 8'h00}, 1'b0, '0},
        '{1'b1, MBC_SPARE, '0, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'h0000, 8'h00}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_WRITE, 16'hA000, 8'h77}, 1'b0, '0},
        '{1'b0, 2'd0, {KIND_READ,  16'hBFFF, 8'h00}, 1'b0, '0}
    };

    localparam logic [1:0] phase_kinds [9] = '{
        MBC_1, MBC_2, MBC_ROM_ONLY, MBC_1, MBC_SPARE, MBC_2, MBC_1, MBC_2, MBC_1
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [1:0] cfg_data = '0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    cbc_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    cbc_rsp_t rsp;

    logic [1:0] bank_kind = MBC_ROM_ONLY;
    logic [6:0] rom_bank_q = 7'd1;
    logic [1:0] ram_bank_q = 2'd0;
    logic       ram_en_q = 1'b0;
    logic       rom_mode_q = 1'b1;

    cbc_rsp_t translations [$];
    cbc_rsp_t want;
    int       idle_pct = 15;
    int       errors = 0;

    cartridge_bank_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void store_rom_bank(logic [6:0] v);
        rom_bank_q = (v == 7'd0) ? 7'd1 : v;
    endfunction

    function automatic cbc_rsp_t translate_access(cbc_req_t a);
        cbc_rsp_t    r;
        logic [20:0] ofs;
        r = '0;
        if (a.address <= 16'h7FFF)
        begin
            if (a.kind == KIND_WRITE)
            begin
                case (bank_kind)
                    MBC_1:
                    begin
                        case (a.address[14:13])
                            RGN_RAM_EN:   ram_en_q = (a.data[3:0] == RAM_EN_KEY);
                            RGN_ROM_BANK: store_rom_bank({rom_bank_q[6:5], a.data[4:0]});
                            RGN_HI_BANK:
                            begin
                                if (rom_mode_q)
                                    store_rom_bank({a.data[1:0], rom_bank_q[4:0]});
                                else
                                    ram_bank_q = a.data[1:0];
                            end
                            default:
                            begin
                                rom_mode_q = ~a.data[0];
                                if (!a.data[0])
                                    ram_bank_q = 2'd0;
                            end
                        endcase
                    end
                    MBC_2:
                    begin
                        if (a.address[14:13] == RGN_RAM_EN && !a.address[4])
                            ram_en_q = (a.data[3:0] == RAM_EN_KEY);
                        else if (a.address[14:13] == RGN_ROM_BANK)
                            store_rom_bank({3'b000, a.data[3:0]});
                    end
                    default: ;
                endcase
            end
            else
            begin
                r.target = TGT_ROM_RD;
                if (bank_kind == MBC_ROM_ONLY || a.address < 16'h4000)
                    r.cart_address = 21'(a.address);
                else
                    r.cart_address = 21'(a.address - 16'h4000) + {rom_bank_q, 14'b0};
            end
        end
        else if (a.address >= 16'hA000 && a.address <= 16'hBFFF)
        begin
            ofs = 21'(a.address - 16'hA000);
            if (bank_kind != MBC_ROM_ONLY)
                ofs = ofs + 21'({ram_bank_q, 13'b0});
            if (a.kind == KIND_READ)
            begin
                r.target = TGT_RAM_RD;
                r.cart_address = ofs;
            end
            else if (bank_kind == MBC_ROM_ONLY || ram_en_q)
            begin
                r.target = TGT_RAM_WR;
                r.cart_address = ofs;
                r.write_data = a.data;
            end
        end
        r.rom_bank_now = rom_bank_q;
        r.ram_bank_now = ram_bank_q;
        return r;
    endfunction

    function automatic cbc_req_t random_access();
        cbc_req_t    a;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        a.kind = KIND_WRITE;
        a.data = 8'($urandom);
        if (pick < 30)
        begin
            a.address = 16'($urandom_range(0, 16'h7FFF));
            if ($urandom_range(0, 1) == 1)
                a.data[3:0] = RAM_EN_KEY;
        end
        else if (pick < 50)
        begin
            a.kind = KIND_READ;
            a.address = 16'($urandom_range(0, 16'h7FFF));
        end
        else if (pick < 65)
        begin
            a.kind = KIND_READ;
            a.address = 16'($urandom_range(16'hA000, 16'hBFFF));
        end
        else if (pick < 85)
            a.address = 16'($urandom_range(16'hA000, 16'hBFFF));
        else
        begin
            a.kind = 1'($urandom);
            a.address = 16'($urandom);
        end
        return a;
    endfunction

    task automatic send_access(input cbc_req_t a, input bit typed, input cbc_rsp_t fixed);
        cbc_rsp_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= a;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = translate_access(a);
        translations.push_back(typed ? fixed : predicted);
    endtask

    task automatic write_kind(input logic [1:0] v);
        req_valid <= 1'b0;
        while (translations.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        bank_kind = v;
    endtask

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (translations.size() == 0)
            begin
                $error("result beat with no access outstanding");
                errors++;
            end
            else
            begin
                want = translations.pop_front();
                if (rsp.target !== want.target)
                begin
                    $error("target: expected %0d, got %0d", want.target, rsp.target);
                    errors++;
                end
                if (rsp.cart_address !== want.cart_address)
                begin
                    $error("cart_address: expected 0x%06h, got 0x%06h",
                           want.cart_address, rsp.cart_address);
                    errors++;
                end
                if (rsp.write_data !== want.write_data)
                begin
                    $error("write_data: expected 0x%02h, got 0x%02h",
                           want.write_data, rsp.write_data);
                    errors++;
                end
                if (rsp.rom_bank_now !== want.rom_bank_now)
                begin
                    $error("rom_bank_now: expected %0d, got %0d",
                           want.rom_bank_now, rsp.rom_bank_now);
                    errors++;
                end
                if (rsp.ram_bank_now !== want.ram_bank_now)
                begin
                    $error("ram_bank_now: expected %0d, got %0d",
                           want.ram_bank_now, rsp.ram_bank_now);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_kind)
                write_kind(directed_rows[i].kind_val);
            else
                send_access(directed_rows[i].acc, directed_rows[i].typed,
                            directed_rows[i].want);
        end
        foreach (phase_kinds[p])
        begin
            write_kind(phase_kinds[p]);
            // hold both sides busy for one whole phase
            idle_pct = (p == 3) ? 0 : 15;
            repeat (150)
                send_access(random_access(), 1'b0, '0);
        end
        req_valid <= 1'b0;
        while (translations.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
